// File: rtl/bmes_pkg.sv
// bicycle model euler step: shared types, constants and tables
// no dependencies
`default_nettype none
package bmes_pkg;

	localparam int CordicIterations = 24;
	localparam int FracBits = 16;
	localparam int IterW = 5;

	localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
	localparam logic signed [31:0] RadToBam = 32'sd683565276;

	// register indexes
	localparam logic [2:0] RegWheelbase = 3'd0;
	localparam logic [2:0] RegSpeedMax = 3'd1;
	localparam logic [2:0] RegSpeedMin = 3'd2;
	localparam logic [2:0] RegSteerMax = 3'd3;
	localparam logic [2:0] RegSteerMin = 3'd4;
	localparam logic [2:0] RegTimeStep = 3'd5;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL_D,
		CMD_ROT_H,
		CMD_ROT_S,
		CMD_CORDIC,
		CMD_STORE_H,
		CMD_STORE_S,
		CMD_DXDY,
		CMD_DIV_TAN,
		CMD_MUL_DT,
		CMD_DIV_PHI,
		CMD_BAM_PHI,
		CMD_COMMIT
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [IterW-1:0] iter;
	} ctl_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic logic signed [31:0] atan_bam(input logic [IterW-1:0] i);
		case (i)
			5'd0: atan_bam = 32'h20000000;
			5'd1: atan_bam = 32'h12E4051D;
			5'd2: atan_bam = 32'h09FB385B;
			5'd3: atan_bam = 32'h051111D4;
			5'd4: atan_bam = 32'h028B0D43;
			5'd5: atan_bam = 32'h0145D7E1;
			5'd6: atan_bam = 32'h00A2F61E;
			5'd7: atan_bam = 32'h00517C55;
			5'd8: atan_bam = 32'h0028BE53;
			5'd9: atan_bam = 32'h00145F2F;
			5'd10: atan_bam = 32'h000A2F98;
			5'd11: atan_bam = 32'h000517CC;
			5'd12: atan_bam = 32'h00028BE6;
			5'd13: atan_bam = 32'h000145F3;
			5'd14: atan_bam = 32'h0000A2F9;
			5'd15: atan_bam = 32'h0000517C;
			5'd16: atan_bam = 32'h000028BE;
			5'd17: atan_bam = 32'h0000145F;
			5'd18: atan_bam = 32'h00000A2F;
			5'd19: atan_bam = 32'h00000517;
			5'd20: atan_bam = 32'h0000028B;
			5'd21: atan_bam = 32'h00000145;
			5'd22: atan_bam = 32'h000000A2;
			5'd23: atan_bam = 32'h00000051;
			5'd24: atan_bam = 32'h00000028;
			5'd25: atan_bam = 32'h00000014;
			5'd26: atan_bam = 32'h0000000A;
			5'd27: atan_bam = 32'h00000005;
			5'd28: atan_bam = 32'h00000002;
			5'd29: atan_bam = 32'h00000001;
			default: atan_bam = 32'h0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF) sat32 = 32'sh7FFFFFFF;
		else if (v < -64'sh80000000) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/bicycle_model_euler_step_unit.sv
// bicycle model euler step: top level, one plant step per input item
// uses bmes_pkg, bmes_ctrl, bmes_datapath
//
// usage: s_axis carries one command item (accel, steer_rate); m_axis returns
// the new state (pos_x, pos_y, heading, speed, steer_angle) for each item.
// configuration registers are written by cfg_we/cfg_index/cfg_data while idle.
// m_axis_tvalid rises after two cordic passes (setup, 24 rotation steps,
// store) through one shared rotation unit, two divides (tangent, then the
// division by the wheelbase) through one shared radix-2 divider, and the
// multiply, position, heading and speed/steering update steps.
// one item is worked at a time; s_axis_tready is high only when idle, so a
// new item is taken only after the last result has been accepted.
// the whole state is updated before the result is shown, so a stalled
// receiver sees a steady result and holds off new items.
// reset clears the plant state to zero and loads the default registers.
`default_nettype none
module bicycle_model_euler_step_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // accel[31:0], steer_rate[63:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [151:0]     m_axis_tdata    // pos_x, pos_y, heading, speed, steer_angle, zero pad
);
	import bmes_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic signed [31:0] pos_x, pos_y, speed;
	logic [31:0]        heading;
	logic signed [17:0] steer_angle;

	bmes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .ctl(ctl), .sts(sts)
	);

	bmes_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .accel(s_axis_tdata[31:0]),
		.steer_rate(s_axis_tdata[63:32]), .ctl(ctl), .sts(sts),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .speed(speed),
		.steer_angle(steer_angle)
	);

	assign m_axis_tdata = {6'd0, steer_angle, speed, heading, pos_y, pos_x};
endmodule
`default_nettype wire

// File: rtl/bmes_div.sv
// bicycle model euler step: signed restoring divider, one quotient bit a cycle
// truncates toward zero; uses bmes_pkg
`default_nettype none
module bmes_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] dividend,
	input  wire logic [31:0]        divisor,
	input  wire logic               divisor_neg,
	output logic signed [63:0]      quotient,
	output logic                    done
);
	import bmes_pkg::*;

	logic [63:0] num_q;
	logic [63:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, num_q[63]} - {33'd0, den_q};

	// magnitude iterations, sign fixed at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
				num_q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
				rem_q <= '0;
				den_q <= divisor;
				neg_q <= dividend[63] ^ divisor_neg;
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					num_q <= {num_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], num_q[63]};
					num_q <= {num_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? 64'(-num_q) : 64'(num_q);
endmodule
`default_nettype wire

// File: rtl/bmes_datapath.sv
// bicycle model euler step: state, config registers, cordic and arithmetic
// uses bmes_pkg and bmes_div
`default_nettype none
module bmes_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic signed [31:0] accel,
	input  wire logic signed [31:0] steer_rate,
	input  wire bmes_pkg::ctl_t     ctl,
	output bmes_pkg::sts_t          sts,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic [31:0]             heading,
	output logic signed [31:0]      speed,
	output logic signed [17:0]      steer_angle
);
	import bmes_pkg::*;

	logic [30:0]        wheelbase_q;
	logic signed [31:0] speed_max_q, speed_min_q;
	logic signed [17:0] steer_max_q, steer_min_q;
	logic [16:0]        time_step_q;
	logic signed [31:0] x_q, y_q, v_q, st_q;
	logic [31:0]        phi_q;
	logic signed [31:0] acc_q, rate_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic signed [33:0] ch_q, sh_q, cd_q, sd_q;
	logic signed [31:0] d_q, tn_q, dphi_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic               div_start;
	logic signed [63:0] div_num, quot;
	logic [31:0]        div_den;
	logic               div_neg, div_done;
	logic signed [33:0] xs, ys;
	logic signed [31:0] ang;
	logic [31:0]        rot_in;
	logic signed [63:0] v_sum, st_sum;
	logic signed [31:0] v_new, st_new;

	assign xs = cx_q >>> ctl.iter;
	assign ys = cy_q >>> ctl.iter;
	assign ang = atan_bam(ctl.iter);

	// one shared 32x32 multiplier, operands picked by command
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.cmd)
			CMD_MUL_D: begin
				mul_a = 32'(signed'({1'b0, time_step_q}));
				mul_b = v_q;
			end
			CMD_ROT_S: begin
				mul_a = st_q;
				mul_b = RadToBam;
			end
			CMD_MUL_DT: begin
				mul_a = d_q;
				mul_b = tn_q;
			end
			CMD_BAM_PHI: begin
				mul_a = dphi_q;
				mul_b = RadToBam;
			end
			default: ;
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	// divider shared by tangent and heading increment
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = 32'd1;
		div_neg = 1'b0;
		if (ctl.cmd == CMD_DIV_TAN) begin
			div_start = 1'b1;
			div_num = 64'(sd_q) <<< FracBits;
			div_den = cd_q[33] ? 32'(-cd_q) : 32'(cd_q);
			div_neg = cd_q[33];
		end else if (ctl.cmd == CMD_DIV_PHI) begin
			div_start = 1'b1;
			div_num = prod_q;
			div_den = (wheelbase_q == '0) ? 32'd1 : {1'b0, wheelbase_q};
		end
	end

	bmes_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .divisor_neg(div_neg), .quotient(quot), .done(div_done)
	);
	assign sts.div_done = div_done;

	// speed and steering update
	assign v_sum = 64'(v_q) + (((64'(signed'({1'b0, time_step_q}))) * 64'(acc_q)) >>> FracBits);
	assign st_sum = 64'(st_q) + (((64'(signed'({1'b0, time_step_q}))) * 64'(rate_q)) >>> FracBits);
	always_comb begin
		v_new = sat32(v_sum);
		if (v_new < speed_min_q) v_new = speed_min_q;
		if (v_new > speed_max_q) v_new = speed_max_q;
		st_new = sat32(st_sum);
		if (st_new < 32'(steer_min_q)) st_new = 32'(steer_min_q);
		if (st_new > 32'(steer_max_q)) st_new = 32'(steer_max_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= 31'd163840;
			speed_max_q <= 32'sd1966080;
			speed_min_q <= '0;
			steer_max_q <= 18'sd32768;
			steer_min_q <= -18'sd32768;
			time_step_q <= 17'd3277;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWheelbase: wheelbase_q <= cfg_data[30:0];
				RegSpeedMax: speed_max_q <= cfg_data;
				RegSpeedMin: speed_min_q <= cfg_data;
				RegSteerMax: steer_max_q <= cfg_data[17:0];
				RegSteerMin: steer_min_q <= cfg_data[17:0];
				RegTimeStep: time_step_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign rot_in = (ctl.cmd == CMD_ROT_H) ? phi_q : 32'(prod >>> FracBits);

	// plant state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			phi_q <= '0;
			v_q <= '0;
			st_q <= '0;
		end else begin
			case (ctl.cmd)
				CMD_LOAD: begin
					acc_q <= accel;
					rate_q <= steer_rate;
				end
				CMD_MUL_D: d_q <= sat32(prod >>> FracBits);
				CMD_ROT_H, CMD_ROT_S: begin
					flip_q <= rot_in[31] ^ rot_in[30];
					cz_q <= 34'(signed'(rot_in[31] ^ rot_in[30] ?
						rot_in + 32'h80000000 : rot_in));
					cx_q <= 34'(CordicGainQ30);
					cy_q <= '0;
				end
				CMD_CORDIC: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - 34'(ang);
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + 34'(ang);
					end
				end
				CMD_STORE_H: begin
					ch_q <= flip_q ? -cx_q : cx_q;
					sh_q <= flip_q ? -cy_q : cy_q;
				end
				CMD_STORE_S: begin
					cd_q <= flip_q ? -cx_q : cx_q;
					sd_q <= flip_q ? -cy_q : cy_q;
				end
				CMD_DXDY: begin
					x_q <= sat32(64'(x_q) + 64'(sat32((64'(d_q) * 64'(ch_q)) >>> 30)));
					y_q <= sat32(64'(y_q) + 64'(sat32((64'(d_q) * 64'(sh_q)) >>> 30)));
				end
				CMD_DIV_TAN: ;
				CMD_MUL_DT: prod_q <= prod;
				CMD_DIV_PHI: ;
				CMD_BAM_PHI: phi_q <= phi_q + prod[FracBits +: 32];
				CMD_COMMIT: begin
					v_q <= v_new;
					st_q <= st_new;
				end
				default: ;
			endcase
			if (div_done) begin
				if (ctl.cmd == CMD_NONE && ctl.iter == 5'd1)
					dphi_q <= sat32(quot);
				else if (cd_q == '0)
					tn_q <= sd_q[33] ? 32'sh80000000 : 32'sh7FFFFFFF;
				else
					tn_q <= sat32(quot);
			end
		end
	end

	assign pos_x = x_q;
	assign pos_y = y_q;
	assign heading = phi_q;
	assign speed = v_q;
	assign steer_angle = st_q[17:0];
endmodule
`default_nettype wire

// File: rtl/bmes_ctrl.sv
// bicycle model euler step: sequencer for one step and the output handshake
// uses bmes_pkg
`default_nettype none
module bmes_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bmes_pkg::ctl_t       ctl,
	input  wire bmes_pkg::sts_t  sts
);
	import bmes_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_MULD, S_ROTH, S_CORH, S_STH, S_ROTS, S_CORS, S_STS,
		S_DXDY, S_DTAN, S_WTAN, S_MULDT, S_DPHI, S_WPHI, S_BAM, S_CMT, S_OUT
	} state_t;

	state_t           state_q;
	logic [IterW-1:0] it_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		ctl.iter = it_q;
		unique case (state_q)
			S_IDLE: ctl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
			S_MULD: ctl.cmd = CMD_MUL_D;
			S_ROTH: ctl.cmd = CMD_ROT_H;
			S_CORH, S_CORS: ctl.cmd = CMD_CORDIC;
			S_STH: ctl.cmd = CMD_STORE_H;
			S_ROTS: ctl.cmd = CMD_ROT_S;
			S_STS: ctl.cmd = CMD_STORE_S;
			S_DXDY: ctl.cmd = CMD_DXDY;
			S_DTAN: ctl.cmd = CMD_DIV_TAN;
			S_MULDT: ctl.cmd = CMD_MUL_DT;
			S_DPHI: ctl.cmd = CMD_DIV_PHI;
			S_BAM: ctl.cmd = CMD_BAM_PHI;
			S_CMT: ctl.cmd = CMD_COMMIT;
			S_OUT: ctl.cmd = CMD_NONE;
			default: ctl.cmd = CMD_NONE;
		endcase
		// marks the heading divide when its quotient returns
		if (state_q == S_WPHI) ctl.iter = 5'd1;
		if (state_q == S_WTAN) ctl.iter = 5'd0;
	end

	// state, iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			it_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MULD;
				S_MULD: state_q <= S_ROTH;
				S_ROTH: begin
					it_q <= '0;
					state_q <= S_CORH;
				end
				S_CORH: begin
					it_q <= it_q + IterW'(1);
					if (it_q == IterW'(CordicIterations - 1)) state_q <= S_STH;
				end
				S_STH: state_q <= S_ROTS;
				S_ROTS: begin
					it_q <= '0;
					state_q <= S_CORS;
				end
				S_CORS: begin
					it_q <= it_q + IterW'(1);
					if (it_q == IterW'(CordicIterations - 1)) state_q <= S_STS;
				end
				S_STS: state_q <= S_DXDY;
				S_DXDY: state_q <= S_DTAN;
				S_DTAN: state_q <= S_WTAN;
				S_WTAN: if (sts.div_done) state_q <= S_MULDT;
				S_MULDT: state_q <= S_DPHI;
				S_DPHI: state_q <= S_WPHI;
				S_WPHI: if (sts.div_done) state_q <= S_BAM;
				S_BAM: state_q <= S_CMT;
				S_CMT: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/bmes_checker.sv
// bicycle model euler step: port-level checks, bound to the top level
// uses no package
`default_nettype none
module bmes_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [151:0] m_axis_tdata
);
	// result held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	// no input taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted with result pending");
	// an accepted item produces no result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");
	// pad bits are zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[151:146] == 6'd0)
		else $error("pad bits set");
endmodule

bind bicycle_model_euler_step_unit bmes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: tb/testbench.sv
// testbench for bicycle_model_euler_step_unit: directed table, then random
// items checked against a behavioral plant predictor; depends on bmes_pkg
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import bmes_pkg::*;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading;
		logic signed [31:0] speed;
		logic signed [17:0] steer_angle;
	} plant_t;

	typedef struct {
		logic [31:0] accel;
		logic [31:0] steer_rate;
		bit          known;
		plant_t      result;
	} row_t;

	typedef struct {
		longint wb, smax, smin, stmax, stmin, ts;
	} setting_t;

	localparam longint Gain = 652032874;
	localparam longint RadBam = 683565276;
	localparam int Settle = 260;

	localparam longint ArcTab [0:23] = '{
		64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
	};

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [31:0]   cfg_data;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata;   // accel[31:0], steer_rate[63:32]
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	// pos_x[31:0], pos_y[63:32], heading[95:64], speed[127:96], steer_angle[145:128]
	logic [151:0]  m_axis_tdata;

	bicycle_model_euler_step_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// predictor copy of plant state and registers
	longint px, py, pv, pst;
	logic [31:0] phd;
	setting_t regs;

	plant_t pending_states[$];
	bit     known_states[$];
	plant_t known_values[$];
	int     fails;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [31:0] to_bam(longint rad);
		longint b;
		b = (rad * RadBam) >>> 16;
		return b[31:0];
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		bit flip;
		logic [31:0] a;
		longint z, x, y, xs, ys;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		a = flip ? ang + 32'h80000000 : ang;
		z = longint'(signed'(a));
		x = Gain;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ArcTab[i];
			end else begin
				x += ys; y -= xs; z += ArcTab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// one euler step of the plant from the old state
	task automatic advance_plant(input longint accel, input longint rate, output plant_t r);
		longint ch, sh, cd, sd, d, dx, dy, tn, dphi, v, st, len;
		len = (regs.wb != 0) ? regs.wb : 1;
		rotate(phd, ch, sh);
		rotate(to_bam(pst), cd, sd);
		d = clip32((regs.ts * pv) >>> 16);
		dx = clip32((d * ch) >>> 30);
		dy = clip32((d * sh) >>> 30);
		if (cd == 0)
			tn = (sd >= 0) ? 64'sd2147483647 : -64'sd2147483648;
		else
			tn = clip32((sd * 65536) / cd);
		dphi = clip32((d * tn) / len);
		v = clip32(pv + ((regs.ts * accel) >>> 16));
		if (v < regs.smin) v = regs.smin;
		if (v > regs.smax) v = regs.smax;
		st = clip32(pst + ((regs.ts * rate) >>> 16));
		if (st < regs.stmin) st = regs.stmin;
		if (st > regs.stmax) st = regs.stmax;
		px = clip32(px + dx);
		py = clip32(py + dy);
		phd = phd + to_bam(dphi);
		pv = v;
		pst = st;
		r.pos_x = px[31:0];
		r.pos_y = py[31:0];
		r.heading = phd;
		r.speed = pv[31:0];
		r.steer_angle = pst[17:0];
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val[31:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(input setting_t s);
		write_reg(RegWheelbase, s.wb);
		write_reg(RegSpeedMax, s.smax);
		write_reg(RegSpeedMin, s.smin);
		write_reg(RegSteerMax, s.stmax);
		write_reg(RegSteerMin, s.stmin);
		write_reg(RegTimeStep, s.ts);
		regs = s;
	endtask

	// present one item, hold until accepted, then predict
	task automatic send_item(input logic [31:0] a, input logic [31:0] w, input bit known,
			input plant_t typed);
		plant_t r;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {w, a};
		do @(posedge clk); while (!s_axis_tready);
		advance_plant(longint'(signed'(a)), longint'(signed'(w)), r);
		pending_states.push_back(r);
		known_states.push_back(known);
		known_values.push_back(typed);
	endtask

	task automatic idle_sender(input int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_states.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			3: return 32'(signed'(int'($urandom_range(0, 2097152)) - 1048576));
			default: return 32'(signed'(int'($urandom_range(0, 524288)) - 262144));
		endcase
	endfunction

	// receiver stall pattern: ready, random stalls half the time, long stalls
	int rx_cnt;
	initial begin
		m_axis_tready = 1'b0;
		rx_cnt = 0;
		forever begin
			@(negedge clk);
			rx_cnt++;
			case ((rx_cnt / 400) % 3)
				0: m_axis_tready = 1'b1;
				1: m_axis_tready = ($urandom_range(0, 1) == 1);
				default: m_axis_tready = ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		plant_t e, g;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			g.pos_x = m_axis_tdata[31:0];
			g.pos_y = m_axis_tdata[63:32];
			g.heading = m_axis_tdata[95:64];
			g.speed = m_axis_tdata[127:96];
			g.steer_angle = m_axis_tdata[145:128];
			if (pending_states.size() == 0) begin
				$display("%0t: unexpected item %h", $time, m_axis_tdata);
				fails++;
			end else begin
				e = pending_states.pop_front();
				if (known_states.pop_front()) begin
					plant_t k;
					k = known_values.pop_front();
					if (k != e) begin
						$display("%0t: table row exp %h predictor %h", $time, k, e);
						fails++;
					end
				end else begin
					void'(known_values.pop_front());
				end
				if (g.pos_x !== e.pos_x) begin
					$display("%0t: pos_x exp %h got %h", $time, e.pos_x, g.pos_x);
					fails++;
				end
				if (g.pos_y !== e.pos_y) begin
					$display("%0t: pos_y exp %h got %h", $time, e.pos_y, g.pos_y);
					fails++;
				end
				if (g.heading !== e.heading) begin
					$display("%0t: heading exp %h got %h", $time, e.heading, g.heading);
					fails++;
				end
				if (g.speed !== e.speed) begin
					$display("%0t: speed exp %h got %h", $time, e.speed, g.speed);
					fails++;
				end
				if (g.steer_angle !== e.steer_angle) begin
					$display("%0t: steer_angle exp %h got %h", $time, e.steer_angle,
						g.steer_angle);
					fails++;
				end
			end
		end
	end

	row_t table_rows[12];
	setting_t phases[7];
	plant_t none;

	initial begin
		int gap, burst;
		fails = 0;
		none = '{default: '0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		regs = '{163840, 1966080, 0, 32768, -32768, 3277};
		px = 0; py = 0; pv = 0; pst = 0; phd = '0;

		// first row from reset: no travel, speed and steering hit the upper clamps
		table_rows[0] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 1, '{0, 0, 0, 1966080, 32768}};
		table_rows[1] = '{32'h80000000, 32'h80000000, 0, none};
		table_rows[2] = '{32'h00000000, 32'h00000000, 0, none};
		table_rows[3] = '{32'h7FFFFFFF, 32'h00000000, 0, none};
		table_rows[4] = '{32'h00010000, 32'h7FFFFFFF, 0, none};
		table_rows[5] = '{32'h00000000, 32'h00010000, 0, none};
		table_rows[6] = '{32'h00000000, 32'h80000000, 0, none};
		table_rows[7] = '{32'h80000000, 32'h00000000, 0, none};
		table_rows[8] = '{32'hFFFF0000, 32'hFFFF0000, 0, none};
		table_rows[9] = '{32'h00000001, 32'hFFFFFFFF, 0, none};
		table_rows[10] = '{32'h40000000, 32'hC0000000, 0, none};
		table_rows[11] = '{32'hFFFFFFFF, 32'h00000001, 0, none};

		phases[0] = '{163840, 1966080, 0, 32768, -32768, 3277};
		phases[1] = '{65536, 64'sd2147483647, -64'sd2147483648, 98304, -98304, 65536};
		phases[2] = '{1, 655360, -655360, 65536, -65536, 1};
		phases[3] = '{64'h7FFFFFFF, 1966080, 0, 32768, -32768, 3277};
		// inverted limits: max clamp wins
		phases[4] = '{163840, 0, 655360, -16384, 16384, 6554};
		phases[5] = '{98304, 3276800, -3276800, 98304, -98304, 32768};
		phases[6] = '{163840, 1966080, 0, 32768, -32768, 3277};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table under reset registers
		foreach (table_rows[i])
			send_item(table_rows[i].accel, table_rows[i].steer_rate, table_rows[i].known,
				table_rows[i].result);
		drain();

		// random phases, one register setting each
		foreach (phases[p]) begin
			apply_setting(phases[p]);
			for (int n = 0; n < 262; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < 262; b++, n++)
					send_item(pick_value(), pick_value(), 0, none);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
				idle_sender(gap);
			end
			drain();
		end

		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/bmes_pkg.sv
rtl/bmes_div.sv
rtl/bmes_datapath.sv
rtl/bmes_ctrl.sv
rtl/bicycle_model_euler_step_unit.sv
rtl/bmes_checker.sv
tb/testbench.sv
